/* design/csvt_pkg.sv */
// Package: codes, types and the per-byte parse function of the CSV field tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

    // Character codes and defaults used when a register holds zero
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] DEF_SEP   = 8'h2C;
    localparam logic [7:0] DEF_QUOTE = 8'h22;

    // Up to three result items per input byte
    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    // Configuration register indexes
    localparam logic CFG_SEP   = 1'b0;
    localparam logic CFG_QUOTE = 1'b1;

    typedef enum logic [2:0] {
        ST_ROW,
        ST_ROWCR,
        ST_FLD,
        ST_UNQ,
        ST_QIN,
        ST_QQ
    } t_pstate;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_FIELD,
        KIND_RECORD
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_res;

    // One parse action: an optional result and the state it leaves
    typedef struct packed {
        logic    hit;
        t_res    res;
        t_pstate st;
    } t_one;

    // All results of one byte and the state after it
    typedef struct packed {
        t_pstate                 st;
        logic [CNT_W-1:0]        num;
        t_res [MAX_RES-1:0]      res;
    } t_run;

    function automatic t_one f_mk(input logic hit, input logic [7:0] data,
                                  input t_kind kind, input t_pstate st);
        t_one o;
        o.hit      = hit;
        o.res.data = data;
        o.res.kind = kind;
        o.st       = st;
        return o;
    endfunction

    // Byte inside or at the start of an unquoted field
    function automatic t_one f_unquoted(input logic [7:0] c, input logic [7:0] sep);
        t_one o;
        priority if (c == sep) begin
            o = f_mk(1'b1, 8'h00, KIND_FIELD, ST_FLD);
        end else if (c == CH_CR || c == CH_LF) begin
            o = f_mk(1'b1, 8'h00, KIND_RECORD, ST_ROW);
        end else begin
            o = f_mk(1'b1, c, KIND_DATA, ST_UNQ);
        end
        return o;
    endfunction

    // Quote test comes first at field start
    function automatic t_one f_field_start(input logic [7:0] c, input logic [7:0] sep,
                                           input logic [7:0] q);
        t_one o;
        if (c == q) begin
            o = f_mk(1'b0, 8'h00, KIND_DATA, ST_QIN);
        end else begin
            o = f_unquoted(c, sep);
        end
        return o;
    endfunction

    // Skip blank lines at row start, hold a CR until the next byte
    function automatic t_one f_row_start(input logic [7:0] c, input logic [7:0] sep,
                                         input logic [7:0] q);
        t_one o;
        priority if (c == CH_LF) begin
            o = f_mk(1'b0, 8'h00, KIND_DATA, ST_ROW);
        end else if (c == CH_CR) begin
            o = f_mk(1'b0, 8'h00, KIND_DATA, ST_ROWCR);
        end else begin
            o = f_field_start(c, sep, q);
        end
        return o;
    endfunction

    // Single-result states; the pending CR and quote-seen states are handled by the caller
    function automatic t_one f_feed(input t_pstate s, input logic [7:0] c,
                                    input logic [7:0] sep, input logic [7:0] q);
        t_one o;
        unique case (s)
            ST_FLD: begin
                o = f_field_start(c, sep, q);
            end
            ST_UNQ: begin
                o = f_unquoted(c, sep);
            end
            ST_QIN: begin
                if (c == q) begin
                    o = f_mk(1'b0, 8'h00, KIND_DATA, ST_QQ);
                end else begin
                    o = f_mk(1'b1, c, KIND_DATA, ST_QIN);
                end
            end
            default: begin
                o = f_row_start(c, sep, q);
            end
        endcase
        return o;
    endfunction

    // Append a result if there is one and take on its state
    function automatic t_run f_add(input t_run r, input t_one o);
        t_run n;
        n = r;
        if (o.hit) begin
            n.res[r.num] = o.res;
            n.num        = r.num + 1'b1;
        end
        n.st = o.st;
        return n;
    endfunction

    // Whole transition for one input byte
    function automatic t_run f_step(input t_pstate s, input logic [7:0] c, input logic last,
                                    input logic [7:0] sep, input logic [7:0] q);
        t_run r;
        r.st  = s;
        r.num = '0;
        r.res = '0;
        unique case (s)
            ST_ROWCR: begin
                if (c == CH_LF) begin
                    r.st = ST_ROW;
                end else begin
                    // lone CR ends a record of its own, then the byte is parsed afresh
                    r = f_add(r, f_field_start(CH_CR, sep, q));
                    r = f_add(r, f_feed(r.st, c, sep, q));
                end
            end
            ST_QQ: begin
                priority if (c == q) begin
                    r = f_add(r, f_mk(1'b1, c, KIND_DATA, ST_QIN));
                end else if (c == sep) begin
                    r = f_add(r, f_mk(1'b1, 8'h00, KIND_FIELD, ST_FLD));
                end else if (c == CH_CR || c == CH_LF) begin
                    r = f_add(r, f_mk(1'b1, 8'h00, KIND_RECORD, ST_ROW));
                end else begin
                    // text after a closing quote ends the record and opens a new row
                    r = f_add(r, f_mk(1'b1, 8'h00, KIND_RECORD, ST_ROW));
                    r = f_add(r, f_row_start(c, sep, q));
                end
            end
            default: begin
                r = f_add(r, f_feed(s, c, sep, q));
            end
        endcase
        // Close an open field on the final byte of the buffer
        if (last) begin
            if (r.st == ST_FLD || r.st == ST_UNQ || r.st == ST_QIN || r.st == ST_QQ) begin
                r = f_add(r, f_mk(1'b1, 8'h00, KIND_RECORD, ST_ROW));
            end
            r.st = ST_ROW;
        end
        return r;
    endfunction

endpackage

/* design/csv_field_tokenizer.sv */
// CSV field tokenizer: byte parser, result bundle register and output register.
`timescale 1ns / 1ps

// Takes one CSV byte per item and yields content bytes, end-of-field and
// end-of-record items, the last result of each byte's run flagged. A byte is
// parsed in the cycle it is accepted and its zero to three results are loaded
// into a bundle register, which drains one result per cycle, while the output
// is not stalled, into the output register; each result passes through the
// bundle register and then the output register. A byte with several results
// holds the bundle until they drain, a limit set by the single result port;
// bytes with no result or one result flow at one per cycle while the output is
// not stalled. Configuration writes are always ready and apply from the next accepted byte.
module csv_field_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]                                r_sep;
    logic [7:0]                                r_quote;
    csvt_pkg::t_pstate                         r_state;
    csvt_pkg::t_pstate                         n_state;
    logic [csvt_pkg::CNT_W-1:0]                r_bnd_left;
    logic [csvt_pkg::CNT_W-1:0]                n_bnd_left;
    logic [csvt_pkg::CNT_W-1:0]                r_bnd_ptr;
    logic [csvt_pkg::CNT_W-1:0]                n_bnd_ptr;
    csvt_pkg::t_res [csvt_pkg::MAX_RES-1:0]    r_bnd_res;
    csvt_pkg::t_res [csvt_pkg::MAX_RES-1:0]    n_bnd_res;
    logic                                      r_out_valid;
    logic                                      n_out_valid;
    csvt_pkg::t_res                            r_out_res;
    csvt_pkg::t_res                            n_out_res;
    logic                                      r_out_last;
    logic                                      n_out_last;

    logic [7:0]       cur_sep;
    logic [7:0]       cur_quote;
    csvt_pkg::t_run   w_run;
    logic             move;
    logic             bnd_free;
    logic             accept;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep   <= csvt_pkg::DEF_SEP;
            r_quote <= csvt_pkg::DEF_QUOTE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csvt_pkg::CFG_SEP:   r_sep   <= i_cfg_data;
                csvt_pkg::CFG_QUOTE: r_quote <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero selects the default character
    assign cur_sep   = (r_sep == 8'h00) ? csvt_pkg::DEF_SEP : r_sep;
    assign cur_quote = (r_quote == 8'h00) ? csvt_pkg::DEF_QUOTE : r_quote;

    // Parse the incoming byte
    assign w_run = csvt_pkg::f_step(r_state, i_in_byte, i_end_of_input, cur_sep, cur_quote);

    // Handshake: bundle drains into the output register when that is free
    assign move     = (r_bnd_left != '0) && (!r_out_valid || !i_stall);
    assign bnd_free = (r_bnd_left == '0) ||
                      (r_bnd_left == csvt_pkg::CNT_W'(1) && move);
    assign o_stall  = !bnd_free;
    assign accept   = i_valid && bnd_free;

    // Next parse state
    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = w_run.st;
        end
    end

    // Bundle and output register updates
    always_comb begin
        n_bnd_left  = r_bnd_left;
        n_bnd_ptr   = r_bnd_ptr;
        n_bnd_res   = r_bnd_res;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        n_out_last  = r_out_last;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (move) begin
            n_out_valid = 1'b1;
            n_out_res   = r_bnd_res[r_bnd_ptr];
            n_out_last  = (r_bnd_left == csvt_pkg::CNT_W'(1));
            n_bnd_left  = r_bnd_left - 1'b1;
            n_bnd_ptr   = r_bnd_ptr + 1'b1;
        end
        if (accept) begin
            n_bnd_left = w_run.num;
            n_bnd_ptr  = '0;
            n_bnd_res  = w_run.res;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csvt_pkg::ST_ROW;
            r_bnd_left  <= '0;
            r_bnd_ptr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bnd_left  <= n_bnd_left;
            r_bnd_ptr   <= n_bnd_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bnd_res  <= n_bnd_res;
        r_out_res  <= n_out_res;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_res.data;
    assign o_kind        = 2'(r_out_res.kind);
    assign o_last_of_run = r_out_last;

    // Checks
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind != 2'd3)
        else $error("result kind out of range");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != 2'(csvt_pkg::KIND_DATA)) |-> o_out_byte == 8'h00)
        else $error("marker item carries a non-zero byte");

    a_end_to_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_input) |=> r_state == csvt_pkg::ST_ROW)
        else $error("final byte did not return the parser to row start");

    a_bnd_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && r_bnd_left != '0) |=> r_bnd_left <= $past(r_bnd_left))
        else $error("bundle grew without an accepted item");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_state))
        else $error("parse state moved without an accepted item");

endmodule
